// File: src/jssf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jssf_pkg: shared types and constants for the JPEG segment span finder
// Marker codes, result status codes, parse phases and the parser state record.
// ----------------------------------------------------------------------------
package jssf_pkg;

  // Width of the byte position counter; the count never exceeds 2^32-1.
  localparam int POSITION_BITS = 32;
  localparam int POS_W = (POSITION_BITS > 32) ? 32 : POSITION_BITS;

  localparam int SPAN_W   = 32;
  localparam int STATUS_W = 3;
  localparam int SEG_W    = 16;

  localparam logic [7:0] MK_PREFIX = 8'hFF;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_EOI    = 8'hD9;
  localparam logic [7:0] MK_SOS    = 8'hDA;
  localparam logic [7:0] MK_TEM    = 8'h01;
  localparam logic [7:0] MK_RST0   = 8'hD0;
  localparam logic [7:0] MK_RST7   = 8'hD7;
  localparam logic [7:0] MK_STUFF  = 8'h00;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 3'd0,
    ST_BAD_SOI  = 3'd1,
    ST_NO_FF    = 3'd2,
    ST_BAD_LEN  = 3'd3,
    ST_TRUNC    = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

  typedef enum logic [9:0] {
    PH_IDLE    = 10'b00_0000_0001,
    PH_SOI0    = 10'b00_0000_0010,
    PH_SOI1    = 10'b00_0000_0100,
    PH_MARK_FF = 10'b00_0000_1000,
    PH_MARK    = 10'b00_0001_0000,
    PH_LEN_HI  = 10'b00_0010_0000,
    PH_LEN_LO  = 10'b00_0100_0000,
    PH_SKIP    = 10'b00_1000_0000,
    PH_SCAN    = 10'b01_0000_0000,
    PH_SCAN_FF = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [POS_W-1:0]   pos;
    logic [SEG_W-1:0]   seg_rem;
    logic [7:0]         len_hi;
    logic               is_scan;
  } parse_state_t;

endpackage : jssf_pkg
`default_nettype wire

// File: src/jssf_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jssf_step: one-byte parser update
// Computes the next parser state and an optional result for one byte.
// ----------------------------------------------------------------------------
module jssf_step (
  input  jssf_pkg::parse_state_t cur,
  input  logic [7:0]             data_byte,
  input  logic                   first_byte,
  input  logic                   final_byte,
  output jssf_pkg::parse_state_t nxt,
  output logic                   emit,
  output logic [jssf_pkg::SPAN_W-1:0] span,
  output jssf_pkg::status_t      status
);
  import jssf_pkg::*;

  parse_state_t     w;
  logic [POS_W-1:0] pos_inc;
  logic [SEG_W-1:0] seg_len;
  logic [SEG_W-1:0] rem_dec;
  logic             is_rst;
  logic             is_marker_alone;
  phase_t           after_seg;

  assign pos_inc = w.pos + POS_W'(1);
  assign seg_len = {w.len_hi, data_byte};
  assign rem_dec = w.seg_rem - SEG_W'(1);
  assign is_rst  = (data_byte >= MK_RST0) && (data_byte <= MK_RST7);
  assign is_marker_alone = (data_byte == MK_TEM) || is_rst;
  assign after_seg = w.is_scan ? PH_SCAN : PH_MARK_FF;

  always_comb begin
    // restart on a first byte
    w = cur;
    if (first_byte) begin
      w.phase   = PH_SOI0;
      w.pos     = '0;
      w.seg_rem = '0;
      w.len_hi  = '0;
      w.is_scan = 1'b0;
    end

    nxt    = w;
    emit   = 1'b0;
    span   = '0;
    status = ST_FOUND;

    if (w.phase == PH_IDLE) begin
      nxt = w;
    end else if (w.pos == '1) begin
      emit   = 1'b1;
      status = ST_OVERFLOW;
    end else begin
      nxt.pos = pos_inc;
      case (w.phase)
        PH_SOI0: begin
          if (data_byte != MK_PREFIX) begin
            emit   = 1'b1;
            status = ST_BAD_SOI;
          end else begin
            nxt.phase = PH_SOI1;
          end
        end
        PH_SOI1: begin
          if (data_byte != MK_SOI) begin
            emit   = 1'b1;
            status = ST_BAD_SOI;
          end else begin
            nxt.phase = PH_MARK_FF;
          end
        end
        PH_MARK_FF: begin
          if (data_byte != MK_PREFIX) begin
            emit   = 1'b1;
            status = ST_NO_FF;
          end else begin
            nxt.phase = PH_MARK;
          end
        end
        PH_LEN_HI: begin
          nxt.len_hi = data_byte;
          nxt.phase  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (seg_len < SEG_W'(2)) begin
            emit   = 1'b1;
            status = ST_BAD_LEN;
          end else begin
            nxt.seg_rem = seg_len - SEG_W'(2);
            nxt.phase   = (seg_len == SEG_W'(2)) ? after_seg : PH_SKIP;
          end
        end
        PH_SKIP: begin
          nxt.seg_rem = rem_dec;
          if (rem_dec == '0) begin
            nxt.phase = after_seg;
          end
        end
        PH_SCAN: begin
          if (data_byte == MK_PREFIX) begin
            nxt.phase = PH_SCAN_FF;
          end
        end
        PH_MARK, PH_SCAN_FF: begin
          if ((w.phase == PH_SCAN_FF) && ((data_byte == MK_STUFF) || is_rst)) begin
            nxt.phase = PH_SCAN;
          end else if (data_byte == MK_EOI) begin
            emit   = 1'b1;
            status = ST_FOUND;
            span   = SPAN_W'(pos_inc);
          end else if (is_marker_alone) begin
            nxt.phase = PH_MARK_FF;
          end else begin
            nxt.is_scan = (data_byte == MK_SOS);
            nxt.phase   = PH_LEN_HI;
          end
        end
        default: begin
          nxt.phase = PH_IDLE;
        end
      endcase

      // out of bytes without a verdict
      if (!emit && final_byte && (nxt.phase != PH_IDLE)) begin
        emit   = 1'b1;
        status = ST_TRUNC;
      end
    end

    if (emit) begin
      nxt.phase = PH_IDLE;
    end
  end

endmodule : jssf_step
`default_nettype wire

// File: src/jpeg_segment_span_finder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jpeg_segment_span_finder_core: JPEG marker segment walker
// Walks SOI, marker segments and scan data, and reports one span or failure
// per buffer.
// ----------------------------------------------------------------------------
// Takes one word (byte) per cycle. A byte with in_first_byte starts a new
// buffer, which must open with FF D8; the walker then follows marker
// segments, skips length-counted payloads and entropy-coded data (passing FF 00
// stuffing and RST pairs), and gives exactly one result per buffer: the span
// from SOI through EOI with status 0, or span 0 with a failure code (1 bad SOI,
// 2 missing FF, 3 bad length, 4 truncated on the final byte, 5 position
// overflow). Bytes after a result are dropped until the next first byte; a
// first byte mid-buffer drops the old buffer without a result. Each byte is
// captured in an input register, passes through the combinational parser
// update and lands in the result register; the rate is one byte per cycle
// while in_stall is low, and in_stall rises only while the result register
// holds a result that the sink stalls.
module jpeg_segment_span_finder_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_first_byte,
  input  logic                        in_final_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [jssf_pkg::SPAN_W-1:0] out_span_length,
  output logic [jssf_pkg::STATUS_W-1:0] out_status
);
  import jssf_pkg::*;

  // input register
  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             s1_first_r;
  logic             s1_last_r;

  // parser state
  parse_state_t     st_r;
  parse_state_t     st_nxt;

  // result register
  logic             out_valid_r;
  logic [SPAN_W-1:0] span_r;
  status_t          status_r;

  logic             step_emit;
  logic [SPAN_W-1:0] step_span;
  status_t          step_status;
  logic             out_free;
  logic             s1_fire;
  logic             in_take;

  // Advance stage one whenever the result register can take a word.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  jssf_step u_step (
    .cur        (st_r),
    .data_byte  (s1_byte_r),
    .first_byte (s1_first_r),
    .final_byte (s1_last_r),
    .nxt        (st_nxt),
    .emit       (step_emit),
    .span       (step_span),
    .status     (step_status)
  );

  // Hold the captured byte while stalled, refill as it drains.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r  <= in_data_byte;
      s1_first_r <= in_first_byte;
      s1_last_r  <= in_final_byte;
    end
  end

  // Parser state advances once per byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase   <= PH_IDLE;
      st_r.pos     <= '0;
      st_r.seg_rem <= '0;
      st_r.len_hi  <= '0;
      st_r.is_scan <= 1'b0;
    end else if (s1_fire) begin
      st_r <= st_nxt;
    end
  end

  // Load a result when one comes out; drop it once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && step_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && step_emit) begin
      span_r   <= step_span;
      status_r <= step_status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_span_length = span_r;
  assign out_status      = status_r;

  // A result always leaves the parser waiting for a new buffer.
  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && step_emit) |=> (st_r.phase == PH_IDLE))
    else $error("parser not idle after result");

  // A found span covers at least FF D8 FF D9.
  a_found_span: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == ST_FOUND)) |-> (span_r >= SPAN_W'(4)))
    else $error("found span too short");

  // Failures carry a zero span.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r != ST_FOUND)) |-> (span_r == '0))
    else $error("failure with nonzero span");

  // Input stalls only while a byte waits behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without cause");

endmodule : jpeg_segment_span_finder_core
`default_nettype wire
